FILE: hdl/srli_pkg.sv
// Package with the shared types, constants and the control store of the row index lookup.
`timescale 1ns / 1ps
`default_nettype none
package srli_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned IDX_W       = 11;
    localparam int unsigned MAX_TABLES  = 1024;
    localparam int unsigned LIVE_AW     = 10;
    localparam int unsigned IN_TDATA_W  = 112;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned STEP_W      = 3;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IDLE = 3'd0;
    localparam t_step STEP_SRCH = 3'd1;
    localparam t_step STEP_RDLO = 3'd2;
    localparam t_step STEP_RDHI = 3'd3;
    localparam t_step STEP_EMIT = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        COND_NEVER    = 2'd0,
        COND_QUERY    = 2'd1,
        COND_MORE     = 2'd2,
        COND_OUT_BUSY = 2'd3
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  srch;
        logic  rd_lo;
        logic  rd_hi;
        logic  emit;
        t_cond cond;
        t_step jump;
        t_step next;
    } t_uop;

    typedef struct packed {
        logic query_in;
        logic more;
        logic out_busy;
    } t_flags;

    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u = '{accept: 1'b0, srch: 1'b0, rd_lo: 1'b0, rd_hi: 1'b0, emit: 1'b0,
              cond: COND_NEVER, jump: STEP_IDLE, next: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                u.accept = 1'b1;
                u.cond   = COND_QUERY;
                u.jump   = STEP_SRCH;
                u.next   = STEP_IDLE;
            end
            STEP_SRCH: begin
                u.srch = 1'b1;
                u.cond = COND_MORE;
                u.jump = STEP_SRCH;
                u.next = STEP_RDLO;
            end
            STEP_RDLO: begin
                u.rd_lo = 1'b1;
                u.next  = STEP_RDHI;
            end
            STEP_RDHI: begin
                u.rd_hi = 1'b1;
                u.next  = STEP_EMIT;
            end
            STEP_EMIT: begin
                u.emit = 1'b1;
                u.cond = COND_OUT_BUSY;
                u.jump = STEP_EMIT;
                u.next = STEP_IDLE;
            end
            default: begin
                u.next = STEP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/srli_sequencer.sv
// Step counter and control store that sequence the lookup datapath.
`timescale 1ns / 1ps
`default_nettype none
module srli_sequencer
    import srli_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_uop        o_uop
);

    t_step r_step;
    t_step n_step;
    t_uop  uop;
    logic  take;

    always_comb begin
        uop = uop_rom(r_step);
        case (uop.cond)
            COND_NEVER:    take = 1'b0;
            COND_QUERY:    take = i_flags.query_in;
            COND_MORE:     take = i_flags.more;
            COND_OUT_BUSY: take = i_flags.out_busy;
            default:       take = 1'b0;
        endcase
        n_step = take ? uop.jump : uop.next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uop = uop;

endmodule
`default_nettype wire

FILE: hdl/srli_datapath.sv
// Offset and size memories, search registers and result register of the lookup.
`timescale 1ns / 1ps
`default_nettype none
module srli_datapath
    import srli_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_uop                   i_uop,
    input  wire logic [IDX_W-1:0]       i_count,
    input  wire logic                   i_s_tvalid,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tuser,
    output t_flags                      o_flags
);

    logic [DATA_W-1:0] starts [0:MAX_TABLES];
    logic [DATA_W-1:0] lives  [0:MAX_TABLES-1];

    logic [IDX_W-1:0]  in_idx;
    logic [DATA_W-1:0] in_start;
    logic [DATA_W-1:0] in_live;
    logic [DATA_W-1:0] in_pos;

    logic [DATA_W-1:0] r_pos;
    logic [IDX_W-1:0]  r_lo;
    logic [IDX_W-1:0]  r_hi;
    logic [IDX_W-1:0]  r_mid;
    logic              r_pend;
    logic [DATA_W-1:0] r_rd_start;
    logic [DATA_W-1:0] r_rd_live;
    logic [DATA_W-1:0] r_row;
    logic              r_s0_le;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [IDX_W-1:0]  r_out_found;
    logic              r_out_hit;

    logic              accepted;
    logic              load_en;
    logic              cmp;
    logic [IDX_W-1:0]  lo_e;
    logic [IDX_W-1:0]  hi_e;
    logic [IDX_W:0]    sum;
    logic [IDX_W-1:0]  mid_e;
    logic              more;
    logic              st_re;
    logic [IDX_W-1:0]  st_addr;
    logic              out_busy;
    logic              hit;

    assign in_idx   = i_s_tdata[10:0];
    assign in_start = i_s_tdata[42:11];
    assign in_live  = i_s_tdata[74:43];
    assign in_pos   = i_s_tdata[106:75];

    assign accepted = i_uop.accept && i_s_tvalid && i_rst_n;
    assign load_en  = accepted && (i_s_tuser == OP_LOAD);

    always_comb begin
        cmp   = r_rd_start <= r_pos;
        lo_e  = (r_pend && cmp) ? r_mid : r_lo;
        hi_e  = (r_pend && !cmp) ? r_mid - 1'b1 : r_hi;
        sum   = {1'b0, lo_e} + {1'b0, hi_e} + 1'b1;
        mid_e = sum[IDX_W:1];
        more  = lo_e < hi_e;

        st_re   = (i_uop.srch && more) || i_uop.rd_lo || i_uop.rd_hi;
        st_addr = r_lo;
        if (i_uop.srch) begin
            st_addr = mid_e;
        end else if (i_uop.rd_hi && (r_lo < i_count)) begin
            st_addr = r_lo + 1'b1;
        end

        out_busy = r_out_valid && !i_m_tready;
        hit      = r_s0_le && (r_lo < i_count) && (r_pos < r_rd_start);
    end

    always_ff @(posedge i_clk) begin
        if (load_en && (in_idx <= IDX_W'(MAX_TABLES))) begin
            starts[in_idx] <= in_start;
            if (in_idx < IDX_W'(MAX_TABLES)) begin
                lives[in_idx[LIVE_AW-1:0]] <= in_live;
            end
        end
        if (st_re) begin
            r_rd_start <= starts[st_addr];
        end
        if (i_uop.rd_lo) begin
            r_rd_live <= lives[r_lo[LIVE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accepted && (i_s_tuser == OP_QUERY)) begin
            r_pend <= 1'b0;
        end else if (i_uop.srch) begin
            r_pend <= more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accepted && (i_s_tuser == OP_QUERY)) begin
            r_pos <= in_pos;
            r_lo  <= '0;
            r_hi  <= i_count;
        end else if (i_uop.srch) begin
            r_lo  <= lo_e;
            r_hi  <= hi_e;
            r_mid <= mid_e;
        end
        if (i_uop.rd_hi) begin
            r_row   <= r_pos - r_rd_start;
            r_s0_le <= r_rd_start <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_uop.emit && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uop.emit && !out_busy) begin
            r_out_value <= (hit && (r_row < r_rd_live)) ? r_row : '0;
            r_out_found <= hit ? r_lo : i_count;
            r_out_hit   <= hit;
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_m_tdata        = {5'd0, r_out_found, r_out_value};
    assign o_m_tuser        = r_out_hit;
    assign o_flags.query_in = i_s_tvalid && (i_s_tuser == OP_QUERY);
    assign o_flags.more     = more;
    assign o_flags.out_busy = out_busy;

endmodule
`default_nettype wire

FILE: hdl/segmented_row_index_lookup_core.sv
// Top level of the segmented row index lookup.
// The slave stream takes load and query beats; tuser bit 0 selects the kind (0 load, 1 query).
// A load beat writes the segment start offset and the live size of one table entry and
// leaves the input ready for the next beat; it gives no result. A query beat gives exactly
// one result beat on the master stream: the row within the found table (zero when out of
// range or not below its live size), the table index, and in tuser the in-range flag.
// A query binary-searches the offset memory through its single read port, one probe per
// cycle (at most 11 probes with 1024 tables), then reads the chosen entry, reads the start
// offset of the entry after it and registers the result. The input is not ready again
// until the result is registered, so no new beat is taken while a query is in flight.
// The config channel writes the table count; it is ready whenever reset is released and
// must only be used while no query is in flight. A count above 1024 is treated as 1024.
// Reset sets the table count to 1 and empties the result register; the memories are not
// cleared and must be loaded before they are queried. No beat is taken during reset.
// While the receiver stalls, the result register holds its beat; a further query runs its
// search and then waits for the register to free.
`timescale 1ns / 1ps
`default_nettype none
module segmented_row_index_lookup_core
    import srli_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [IDX_W-1:0]       i_cfg_data,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // entry_index, start_offset, live_size, row_position, zero padding
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // op
    input  wire logic                   i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // lookup_value, found_table, zero padding
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // in_range
    output logic                        o_m_tuser
);

    logic [IDX_W-1:0] r_table_count;
    logic [IDX_W-1:0] count;
    t_uop             uop;
    t_flags           flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_count <= IDX_W'(1);
        end else if (i_cfg_valid) begin
            r_table_count <= i_cfg_data;
        end
    end

    assign count       = (r_table_count > IDX_W'(MAX_TABLES)) ? IDX_W'(MAX_TABLES)
                                                              : r_table_count;
    assign o_cfg_ready = i_rst_n;
    assign o_s_tready  = uop.accept && i_rst_n;

    srli_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uop   (uop)
    );

    srli_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uop      (uop),
        .i_count    (count),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_flags    (flags)
    );

endmodule
`default_nettype wire

FILE: hdl/srli_checker.sv
// Port-level checker for the row index lookup and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module srli_checker
    import srli_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   o_s_tready,
    input wire logic                   i_s_tuser,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("Result beat changed while stalled.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[31:0] == 32'd0)
        else $error("Out-of-range result carries a non-zero row.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser |=> !o_s_tready)
        else $error("Input taken during a query search.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result valid straight after reset.");

endmodule

bind segmented_row_index_lookup_core srli_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
